@@ rtl/armdp_pkg.sv @@
// Shared types and constants for the data-processing execute block.
// Holds status codes, opcode values, flag bit positions and the result record.
// No dependencies.
`default_nettype none

package armdp_pkg;

  typedef enum logic [2:0] {
    ST_EXEC        = 3'd0,
    ST_COND_FAIL   = 3'd1,
    ST_UNSUPPORTED = 3'd2,
    ST_PC_OPERAND  = 3'd3,
    ST_S_MISSING   = 3'd4
  } armdp_status_t;

  localparam logic [3:0] OP_SUB = 4'd2;
  localparam logic [3:0] OP_ADD = 4'd4;
  localparam logic [3:0] OP_TST = 4'd8;
  localparam logic [3:0] OP_CMP = 4'd10;
  localparam logic [3:0] OP_ORR = 4'd12;
  localparam logic [3:0] OP_MOV = 4'd13;
  localparam logic [3:0] OP_BIC = 4'd14;

  localparam logic [1:0] SH_LSL = 2'd0;
  localparam logic [1:0] SH_LSR = 2'd1;
  localparam logic [1:0] SH_ASR = 2'd2;
  localparam logic [1:0] SH_ROR = 2'd3;

  localparam logic [3:0] COND_NEVER = 4'd15;
  localparam logic [3:0] REG_PC     = 4'd15;

  localparam int FL_N = 3;
  localparam int FL_Z = 2;
  localparam int FL_C = 1;
  localparam int FL_V = 0;

  // Status-register-read pattern that shares the data-processing space.
  localparam logic [31:0] MRS_MASK  = 32'h0fbf_0fff;
  localparam logic [31:0] MRS_MATCH = 32'h010f_0000;

  typedef struct packed {
    armdp_status_t status;
    logic          write_enable;
    logic [3:0]    dest_reg;
    logic [31:0]   result_value;
    logic [3:0]    flags_out;
    logic          pc_written;
  } armdp_result_t;

endpackage

`default_nettype wire

@@ rtl/arm_data_processing_execute_top.sv @@
// Data-processing execute stage: input register, ALU, result register.
// Beats pass the input and then the result register; while out_ready is high, one beat
// per cycle is sustained, as the flag register is written in time for the next item.
// The NZCV flags are updated as an item moves from the input to the result register.
// Reset clears both valid bits and the flags; payload registers are not reset.
// Depends on armdp_pkg and armdp_alu.
`default_nettype none

module arm_data_processing_execute_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_instruction,
  input  logic [31:0] in_first_operand,
  input  logic [31:0] in_shifted_operand,
  input  logic [31:0] in_shift_register_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic        out_write_enable,
  output logic [3:0]  out_dest_reg,
  output logic [31:0] out_result_value,
  output logic [3:0]  out_flags_out,
  output logic        out_pc_written
);
  import armdp_pkg::*;

  logic          s1_valid_r, s1_valid_nxt;
  logic [31:0]   s1_inst_r, s1_rn_r, s1_rm_r, s1_rs_r;
  logic          out_valid_r, out_valid_nxt;
  armdp_result_t out_r;
  logic [3:0]    flags_r, flags_nxt;
  armdp_result_t alu_res;
  logic          in_accept, advance;

  armdp_alu u_alu (
    .instruction          (s1_inst_r),
    .first_operand        (s1_rn_r),
    .shifted_operand      (s1_rm_r),
    .shift_register_value (s1_rs_r),
    .flags_in             (flags_r),
    .result               (alu_res)
  );

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign in_accept = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    // The ALU passes the stored flags through unless the item sets them.
    flags_nxt = advance ? alu_res.flags_out : flags_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= 4'd0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      flags_r     <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_inst_r <= in_instruction;
      s1_rn_r   <= in_first_operand;
      s1_rm_r   <= in_shifted_operand;
      s1_rs_r   <= in_shift_register_value;
    end
    if (advance) begin
      out_r <= alu_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_write_enable = out_r.write_enable;
  assign out_dest_reg     = out_r.dest_reg;
  assign out_result_value = out_r.result_value;
  assign out_flags_out    = out_r.flags_out;
  assign out_pc_written   = out_r.pc_written;

  a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(flags_r))
    else $error("flags changed without an item leaving the input register");

  a_no_write_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != ST_EXEC) |->
      (!out_r.write_enable && out_r.result_value == 32'd0 && !out_r.pc_written))
    else $error("non-executed result carries a write");

  a_pc_written: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.pc_written) |-> (out_r.write_enable && out_r.dest_reg == REG_PC))
    else $error("pc_written without a write to register 15");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled while the result register is empty");

endmodule

`default_nettype wire

@@ rtl/armdp_alu.sv @@
// Combinational decode, operand-two shifter and ALU for one instruction.
// Produces the full result record from the instruction, operands and current flags.
// Depends on armdp_pkg.
`default_nettype none

module armdp_alu (
  input  logic [31:0]             instruction,
  input  logic [31:0]             first_operand,
  input  logic [31:0]             shifted_operand,
  input  logic [31:0]             shift_register_value,
  input  logic [3:0]              flags_in,
  output armdp_pkg::armdp_result_t result
);
  import armdp_pkg::*;

  function automatic logic cond_holds(input logic [3:0] cond, input logic [3:0] f);
    logic n, z, c, v, ok;
    n = f[FL_N];
    z = f[FL_Z];
    c = f[FL_C];
    v = f[FL_V];
    case (cond)
      4'd0:    ok = z;
      4'd1:    ok = !z;
      4'd2:    ok = c;
      4'd3:    ok = !c;
      4'd4:    ok = n;
      4'd5:    ok = !n;
      4'd6:    ok = v;
      4'd7:    ok = !v;
      4'd8:    ok = !z && c;
      4'd9:    ok = !c || z;
      4'd10:   ok = (n == v);
      4'd11:   ok = (n != v);
      4'd12:   ok = !z && (n == v);
      4'd13:   ok = z || (n != v);
      default: ok = 1'b1;
    endcase
    return ok;
  endfunction

  function automatic logic [31:0] rotr32(input logic [31:0] v, input logic [4:0] n);
    logic [63:0] both;
    both = {v, v} >> n;
    return both[31:0];
  endfunction

  function automatic logic [31:0] shift_value(input logic [31:0] v, input logic [1:0] kind,
                                              input logic [7:0] amt);
    logic        big;
    logic [31:0] r;
    big = (amt[7:5] != 3'd0);
    if (amt == 8'd0) begin
      r = v;
    end else begin
      case (kind)
        SH_LSL:  r = big ? 32'd0 : (v << amt[4:0]);
        SH_LSR:  r = big ? 32'd0 : (v >> amt[4:0]);
        SH_ASR:  r = big ? {32{v[31]}} : $unsigned($signed(v) >>> amt[4:0]);
        default: r = rotr32(v, amt[4:0]);
      endcase
    end
    return r;
  endfunction

  logic [3:0]  cond, op, rn, rd;
  logic        imm, s_bit, reg_amt, op_known, bad_enc;
  logic [7:0]  amt;
  logic [31:0] op2, val;
  logic [32:0] sum, diff;
  logic        logic_op, carry, ovf;

  assign cond    = instruction[31:28];
  assign op      = instruction[24:21];
  assign imm     = instruction[25];
  assign s_bit   = instruction[20];
  assign rn      = instruction[19:16];
  assign rd      = instruction[15:12];
  assign reg_amt = !imm && instruction[4];
  assign amt     = reg_amt ? shift_register_value[7:0] : {3'd0, instruction[11:7]};

  always_comb begin
    case (op)
      OP_ORR, OP_BIC, OP_MOV, OP_ADD, OP_SUB, OP_CMP, OP_TST: op_known = 1'b1;
      default: op_known = 1'b0;
    endcase
  end

  assign bad_enc = (instruction[27:26] != 2'd0) || !op_known ||
                   (!imm && instruction[7] && instruction[4]) ||
                   ((instruction & MRS_MASK) == MRS_MATCH) || (cond == COND_NEVER);

  assign op2 = imm ? rotr32({24'd0, instruction[7:0]}, {instruction[11:8], 1'b0})
                   : shift_value(shifted_operand, instruction[6:5], amt);

  assign sum  = {1'b0, first_operand} + {1'b0, op2};
  assign diff = {1'b0, first_operand} - {1'b0, op2};

  always_comb begin
    logic_op = 1'b1;
    carry    = 1'b0;
    ovf      = 1'b0;
    case (op)
      OP_ORR: val = first_operand | op2;
      OP_BIC: val = first_operand & ~op2;
      OP_MOV: val = op2;
      OP_TST: val = first_operand & op2;
      OP_ADD: begin
        logic_op = 1'b0;
        val      = sum[31:0];
        carry    = sum[32];
        ovf      = ~(first_operand[31] ^ op2[31]) & (first_operand[31] ^ sum[31]);
      end
      default: begin
        logic_op = 1'b0;
        val      = diff[31:0];
        carry    = ~diff[32];
        ovf      = (first_operand[31] ^ op2[31]) & (first_operand[31] ^ diff[31]);
      end
    endcase
  end

  always_comb begin
    result.status       = ST_EXEC;
    result.write_enable = 1'b0;
    result.dest_reg     = rd;
    result.result_value = 32'd0;
    result.flags_out    = flags_in;
    result.pc_written   = 1'b0;
    if (bad_enc) begin
      result.status = ST_UNSUPPORTED;
    end else if (!cond_holds(cond, flags_in)) begin
      result.status = ST_COND_FAIL;
    end else if ((rn == REG_PC && op != OP_MOV) ||
                 (reg_amt && instruction[11:8] == REG_PC) ||
                 (rd == REG_PC && s_bit)) begin
      result.status = ST_PC_OPERAND;
    end else if (!s_bit && (op == OP_CMP || op == OP_TST)) begin
      result.status = ST_S_MISSING;
    end else begin
      if (s_bit) begin
        result.flags_out[FL_N] = val[31];
        result.flags_out[FL_Z] = (val == 32'd0);
        result.flags_out[FL_C] = logic_op ? 1'b0 : carry;
        result.flags_out[FL_V] = logic_op ? flags_in[FL_V] : ovf;
      end
      if (op != OP_CMP && op != OP_TST) begin
        result.write_enable = 1'b1;
        result.result_value = val;
        result.pc_written   = (rd == REG_PC);
      end
    end
  end

endmodule

`default_nettype wire
